// File: rtl/assert_macros.svh
// assertion macros shared by the picker rtl
// no dependencies; ASSERT_OFF removes every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/rrqp_pkg.sv
// package for the round-robin queue picker: widths, register indexes, payload types
// no dependencies
package rrqp_pkg;

    localparam int MAX_QUEUES_DEF = 16;
    localparam int MASK_W         = 16;
    localparam int BASE_W         = 10;
    localparam int CNT_REG_W      = 5;
    localparam int ID_W           = 11;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic REG_POOL_BASE   = 1'b0;
    localparam logic REG_QUEUE_COUNT = 1'b1;

    typedef struct packed {
        logic [MASK_W-1:0] disabled_mask;
        logic [MASK_W-1:0] full_mask;
    } req_t;

    typedef struct packed {
        logic            granted;
        logic [ID_W-1:0] queue_id;
        logic            granted_full;
    } rsp_t;

    typedef struct packed {
        logic usable;
        logic eligible;
        logic upper;
    } lane_status_t;

endpackage

// File: rtl/rrqp_lane.sv
// one lane: status of a single pool queue relative to the round-robin start
// depends on rrqp_pkg
module rrqp_lane
    import rrqp_pkg::*;
#(
    parameter int LANE_IDX = 0,
    parameter int N_W      = 5,
    parameter int OFF_W    = 4
)
(
    input  logic             disabled,
    input  logic             full,
    input  logic [N_W-1:0]   queue_n,
    input  logic [OFF_W-1:0] start,
    output lane_status_t     status
);

    logic in_pool;

    assign in_pool         = N_W'(LANE_IDX) < queue_n;
    assign status.usable   = in_pool && !disabled;
    assign status.eligible = in_pool && !disabled && !full;
    assign status.upper    = OFF_W'(LANE_IDX) >= start;

endmodule

// File: rtl/rrqp_merge.sv
// merge stage: first eligible lane from the start, wrap, then pointer fallback
// depends on rrqp_pkg and the lane status
module rrqp_merge
    import rrqp_pkg::*;
#(
    parameter int MAX_QUEUES = MAX_QUEUES_DEF,
    parameter int OFF_W      = 4
)
(
    input  lane_status_t      lanes [MAX_QUEUES],
    input  logic [OFF_W-1:0]  start,
    input  logic [BASE_W-1:0] pool_base,
    output rsp_t              rsp
);

    logic             found_hi;
    logic             found_any;
    logic [OFF_W-1:0] pick_hi;
    logic [OFF_W-1:0] pick_any;
    logic [OFF_W-1:0] pick;
    logic             fallback;

    always_comb
    begin
        found_hi  = 1'b0;
        found_any = 1'b0;
        pick_hi   = '0;
        pick_any  = '0;
        for (int i = MAX_QUEUES - 1; i >= 0; i--)
        begin
            if (lanes[i].eligible && lanes[i].upper)
            begin
                found_hi = 1'b1;
                pick_hi  = OFF_W'(i);
            end
            if (lanes[i].eligible)
            begin
                found_any = 1'b1;
                pick_any  = OFF_W'(i);
            end
        end
    end

    assign fallback = !found_any && lanes[start].usable;
    assign pick     = found_hi ? pick_hi : (found_any ? pick_any : start);

    always_comb
    begin
        rsp.granted      = found_any || fallback;
        rsp.granted_full = fallback;
        if (found_any || fallback)
        begin
            rsp.queue_id = ID_W'(pool_base) + ID_W'(pick);
        end
        else
        begin
            rsp.queue_id = '0;
        end
    end

endmodule

// File: rtl/rrqp_out_buf.sv
// output register with skid stage so a new transaction is taken while a result waits
// depends on rrqp_pkg and assert_macros.svh
`include "assert_macros.svh"
module rrqp_out_buf
    import rrqp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rsp_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    rsp_t out_data_reg;
    rsp_t skid_data_reg;
    logic pop;
    logic push;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = out_valid_reg && out_ready;
    assign push      = in_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_data_reg <= in_data;
        end
        else if (push)
        begin
            skid_data_reg <= in_data;
        end
    end

    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full while output empty")
    `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, push && out_valid_reg && !out_ready, skid_valid_reg, "stalled transaction lost")
    `ASSERT_NEXT(a_skid_drains_first, clk, rst_n, skid_valid_reg && pop, out_data_reg == $past(skid_data_reg), "skid entry out of order")

endmodule

// File: rtl/round_robin_queue_picker_top.sv
// round-robin queue picker: one lane per pool queue, merge, then output buffer
// the result of an accepted request transaction is registered in the output buffer
// throughput: one transaction per cycle while req_ready is high; lane and merge logic is combinational
// a stalled output holds one result plus one in the skid stage before req_ready drops
// reset: pool_base 0, queue_count 1, pointer 0, output buffer empty
// depends on rrqp_pkg, rrqp_lane, rrqp_merge, rrqp_out_buf and assert_macros.svh
`include "assert_macros.svh"
module round_robin_queue_picker_top
    import rrqp_pkg::*;
#(
    parameter int MAX_QUEUES = MAX_QUEUES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    localparam int N_W   = $clog2(MAX_QUEUES + 1);
    localparam int OFF_W = $clog2(MAX_QUEUES);
    localparam int CMP_W = (N_W > CNT_REG_W) ? N_W : CNT_REG_W;

    logic [BASE_W-1:0]    pool_base_reg;
    logic [CNT_REG_W-1:0] queue_count_reg;
    logic [OFF_W-1:0]     ptr_reg;
    logic [OFF_W-1:0]     ptr_next;
    logic                 cfg_wr;
    logic                 reg_idx;
    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     n_sat;
    logic [N_W-1:0]       queue_n;
    logic [OFF_W-1:0]     start;
    logic [N_W-1:0]       start_inc;
    logic                 accept;
    lane_status_t         lanes [MAX_QUEUES];
    rsp_t                 pick_rsp;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            REG_POOL_BASE:   prdata = APB_DATA_W'(pool_base_reg);
            REG_QUEUE_COUNT: prdata = APB_DATA_W'(queue_count_reg);
            default:         prdata = '0;
        endcase
    end

    // effective count: zero reads as one, saturate at the lane count
    assign count_ext = CMP_W'(queue_count_reg);
    always_comb
    begin
        if (queue_count_reg == '0)
        begin
            n_sat = CMP_W'(1);
        end
        else if (count_ext > CMP_W'(MAX_QUEUES))
        begin
            n_sat = CMP_W'(MAX_QUEUES);
        end
        else
        begin
            n_sat = count_ext;
        end
    end
    assign queue_n = N_W'(n_sat);

    assign start     = (N_W'(ptr_reg) >= queue_n) ? '0 : ptr_reg;
    assign start_inc = N_W'(start) + N_W'(1);
    assign ptr_next  = (start_inc >= queue_n) ? '0 : OFF_W'(start_inc);
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            queue_count_reg <= CNT_REG_W'(1);
            ptr_reg         <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_POOL_BASE:
                begin
                    pool_base_reg <= pwdata[BASE_W-1:0];
                end
                REG_QUEUE_COUNT:
                begin
                    queue_count_reg <= pwdata[CNT_REG_W-1:0];
                    ptr_reg         <= '0;
                end
                default:
                begin
                    pool_base_reg <= pool_base_reg;
                end
            endcase
        end
        else if (accept)
        begin
            ptr_reg <= ptr_next;
        end
    end

    for (genvar i = 0; i < MAX_QUEUES; i++)
    begin : g_lane
        logic dis_bit;
        logic full_bit;
        if (i < MASK_W)
        begin : g_mask
            assign dis_bit  = req.disabled_mask[i];
            assign full_bit = req.full_mask[i];
        end
        else
        begin : g_clear
            assign dis_bit  = 1'b0;
            assign full_bit = 1'b0;
        end
        rrqp_lane #(
            .LANE_IDX (i),
            .N_W      (N_W),
            .OFF_W    (OFF_W)
        ) u_lane (
            .disabled (dis_bit),
            .full     (full_bit),
            .queue_n  (queue_n),
            .start    (start),
            .status   (lanes[i])
        );
    end

    rrqp_merge #(
        .MAX_QUEUES (MAX_QUEUES),
        .OFF_W      (OFF_W)
    ) u_merge (
        .lanes      (lanes),
        .start      (start),
        .pool_base  (pool_base_reg),
        .rsp        (pick_rsp)
    );

    rrqp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_ready   (req_ready),
        .in_data    (pick_rsp),
        .out_valid  (rsp_valid),
        .out_ready  (rsp_ready),
        .out_data   (rsp)
    );

    `ASSERT_IMPLIES(a_ptr_in_pool, clk, rst_n, 1'b1, N_W'(ptr_reg) < queue_n, "pointer beyond pool")
    `ASSERT_IMPLIES(a_full_needs_grant, clk, rst_n, rsp_valid && rsp.granted_full, rsp.granted, "full flag without grant")
    `ASSERT_IMPLIES(a_no_grant_zero, clk, rst_n, rsp_valid && !rsp.granted, rsp.queue_id == '0, "queue id set without grant")

endmodule

// File: test/round_robin_queue_picker_top_tb.sv
// testbench for round_robin_queue_picker_top: directed and random request transactions
// with an in-bench grant predictor, apb register writes and read-back, random stalls
// depends on rrqp_pkg and the picker rtl
`timescale 1ns / 1ps
module round_robin_queue_picker_top_tb;
    import rrqp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;

    logic [BASE_W-1:0]     pool_base_q;
    logic [CNT_REG_W-1:0]  queue_count_q;
    logic [3:0]            rr_pointer;
    rsp_t                  expected_grants[$];

    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;
    int unsigned           mismatches;
    int unsigned           stall_cycles;

    round_robin_queue_picker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic rsp_t pick_queue(input req_t item);
        int unsigned n;
        int unsigned start;
        int unsigned q;
        int unsigned pick;
        logic        found;
        logic        fallback;
        rsp_t        res;
        n = queue_count_q;
        if (n == 0)
            n = 1;
        if (n > MAX_QUEUES_DEF)
            n = MAX_QUEUES_DEF;
        start = rr_pointer;
        if (start >= n)
            start = 0;
        rr_pointer = (start + 1 >= n) ? 4'd0 : 4'(start + 1);
        found    = 1'b0;
        fallback = 1'b0;
        pick     = 0;
        for (int unsigned k = 0; k < n; k++)
        begin
            q = start + k;
            if (q >= n)
                q -= n;
            if (!found && !item.disabled_mask[q] && !item.full_mask[q])
            begin
                found = 1'b1;
                pick  = q;
            end
        end
        if (!found && !item.disabled_mask[start])
        begin
            found    = 1'b1;
            fallback = 1'b1;
            pick     = start;
        end
        res.granted      = found;
        res.queue_id     = found ? ID_W'(pool_base_q + pick) : '0;
        res.granted_full = fallback;
        return res;
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        case ($urandom_range(5))
            0: m = '0;
            1: m = '1;
            2: m = MASK_W'($urandom) & MASK_W'($urandom);
            3: m = MASK_W'($urandom) | MASK_W'($urandom) | MASK_W'($urandom);
            4: m = ~(MASK_W'(1) << $urandom_range(MASK_W - 1));
            default: m = MASK_W'($urandom);
        endcase
        return m;
    endfunction

    // predictor runs on request acceptance, checker on result acceptance
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: granted=%0b id=%0d full=%0b",
                                 rsp.granted, rsp.queue_id, rsp.granted_full);
                end
                else
                begin
                    exp_rsp = expected_grants.pop_front();
                    if (rsp.granted !== exp_rsp.granted || rsp.queue_id !== exp_rsp.queue_id
                        || rsp.granted_full !== exp_rsp.granted_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("grant mismatch: exp granted=%0b id=%0d full=%0b, act granted=%0b id=%0d full=%0b",
                                     exp_rsp.granted, exp_rsp.queue_id, exp_rsp.granted_full,
                                     rsp.granted, rsp.queue_id, rsp.granted_full);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_grants.push_back(pick_queue(req));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                || (psel && penable && pready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_request(input logic [MASK_W-1:0] dis, input logic [MASK_W-1:0] full);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req.disabled_mask <= dis;
        req.full_mask     <= full;
        req_valid         <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // apb write then read-back, predictor updated at the write edge
    task automatic set_register(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] exp_rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_idx == REG_POOL_BASE)
            pool_base_q = value[BASE_W-1:0];
        else
        begin
            queue_count_q = value[CNT_REG_W-1:0];
            rr_pointer    = '0;
        end
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        exp_rd = (reg_idx == REG_POOL_BASE) ? APB_DATA_W'(pool_base_q)
                                            : APB_DATA_W'(queue_count_q);
        if (prdata !== exp_rd)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register read-back mismatch at %0d: exp %0h act %0h",
                         {reg_idx, 2'b00}, exp_rd, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(16'h0000, 16'h0000);
        send_request(16'h0000, 16'h0001);
        send_request(16'h0001, 16'h0000);
        send_request(16'hFFFE, 16'hFFFE);
        wait_drained();
    endtask

    task automatic test_pointer_wrap();
        set_register(REG_POOL_BASE, 32'd1023);
        set_register(REG_QUEUE_COUNT, 32'd16);
        send_request(16'h0000, 16'h0000);
        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'h0000, 16'hFFFF);
        send_request(16'h7FFF, 16'h0000);
        send_request(16'h00F0, 16'h0F0F);
        wait_drained();
    endtask

    task automatic test_count_limits();
        set_register(REG_QUEUE_COUNT, 32'd0);
        send_request(16'h0000, 16'h0001);
        send_request(16'hFFFE, 16'h0000);
        wait_drained();
        set_register(REG_QUEUE_COUNT, 32'd17);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'h0000, 16'h7FFF);
        wait_drained();
        set_register(REG_QUEUE_COUNT, 32'd31);
        set_register(REG_POOL_BASE, 32'd0);
        send_request(16'hBFFF, 16'h0000);
        send_request(16'h8000, 16'h7FFF);
        wait_drained();
        set_register(REG_QUEUE_COUNT, 32'hFFFF_FFE2);
        set_register(REG_POOL_BASE, 32'hFFFF_FD55);
        send_request(16'hFFFC, 16'hFFFC);
        send_request(16'h0001, 16'h0002);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned s_idle, input int unsigned r_idle);
        logic [APB_DATA_W-1:0] cnt;
        logic [APB_DATA_W-1:0] base;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int s = 0; s < 4; s++)
        begin
            case ($urandom_range(5))
                0: cnt = 32'd1;
                1: cnt = 32'd16;
                2: cnt = 32'd0;
                3: cnt = $urandom_range(31);
                default: cnt = $urandom_range(2, 8);
            endcase
            cnt[APB_DATA_W-1:CNT_REG_W] = (APB_DATA_W-CNT_REG_W)'($urandom);
            case ($urandom_range(3))
                0: base = 32'd0;
                1: base = 32'd1023;
                default: base = $urandom;
            endcase
            set_register(REG_POOL_BASE, base);
            set_register(REG_QUEUE_COUNT, cnt);
            for (int i = 0; i < 50; i++)
                send_request(random_mask(), random_mask());
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_ready     = 1'b0;
        pool_base_q   = '0;
        queue_count_q = CNT_REG_W'(1);
        rr_pointer    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatches    = 0;
        stall_cycles  = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_pointer_wrap();
        test_count_limits();
        test_random_traffic(8, 57);
        test_random_traffic(57, 8);
        test_random_traffic(0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_grants.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
